// ===== rtl/ffea_pkg.sv =====
// shared types, codes and defaults of the first-fit extent allocator
`timescale 1ns / 1ps
`default_nettype none

package ffea_pkg;

    localparam int DEF_MAX_EXTENTS = 16;
    localparam int DEF_ADDR_WIDTH  = 16;

    localparam int FIELD_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0] REGION_BASE_RST = 16'h0000;
    localparam logic [FIELD_W-1:0] REGION_SIZE_RST = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO  = 2'd3;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    // token rippled down the chain, one cell per cycle
    // alloc: hit = target found upstream, rm = target extent empties
    // release: hit = insert point found, rm = joins predecessor, jn = joins successor
    typedef struct packed {
        logic hit;
        logic rm;
        logic jn;
    } t_tok;

    // control broadcast to every cell
    typedef struct packed {
        logic scan;
        logic apply;
        logic reload;
        logic kind;
        logic full;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/ffea_cell.sv =====
// one extent cell of the allocator chain
`timescale 1ns / 1ps
`default_nettype none

module ffea_cell #(
    parameter int ADDR_WIDTH = ffea_pkg::DEF_ADDR_WIDTH
) (
    input  logic                  i_clk,
    input  ffea_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_head,
    input  logic [ADDR_WIDTH-1:0] i_req_start,
    input  logic [ADDR_WIDTH-1:0] i_req_size,
    input  logic [ADDR_WIDTH:0]   i_req_end,
    input  logic [ADDR_WIDTH-1:0] i_ld_start,
    input  logic [ADDR_WIDTH-1:0] i_ld_len,
    input  logic                  i_ld_valid,
    input  logic                  i_l_valid,
    input  logic [ADDR_WIDTH-1:0] i_l_start,
    input  logic [ADDR_WIDTH-1:0] i_l_len,
    input  logic                  i_l_le,
    input  logic                  i_l_match_end,
    input  ffea_pkg::t_tok        i_l_tok,
    input  logic [ADDR_WIDTH-1:0] i_l_grant,
    input  logic                  i_r_valid,
    input  logic [ADDR_WIDTH-1:0] i_r_start,
    input  logic [ADDR_WIDTH-1:0] i_r_len,
    input  logic                  i_r_le,
    input  logic                  i_r_match_start,
    output logic                  o_valid,
    output logic [ADDR_WIDTH-1:0] o_start,
    output logic [ADDR_WIDTH-1:0] o_len,
    output logic                  o_le,
    output logic                  o_match_end,
    output logic                  o_match_start,
    output ffea_pkg::t_tok        o_tok,
    output logic [ADDR_WIDTH-1:0] o_grant
);
    import ffea_pkg::*;

    localparam int AW = ADDR_WIDTH;
    localparam logic [AW-1:0] LEN_MAX = '1;

    logic          r_valid, n_valid;
    logic [AW-1:0] r_start, n_start;
    logic [AW-1:0] r_len,   n_len;
    t_tok          r_tok,   n_tok;
    logic [AW-1:0] r_grant, n_grant;

    logic          le, match_end, match_start, fit, empties, gen;
    logic [AW:0]   end_sum;
    logic [AW-1:0] rest, gen_grant, sat1, sat2;
    logic [AW+1:0] sum1, sum2;
    t_tok          gen_tok, own_tok;

    always_comb begin
        le          = r_valid && (r_start <= i_req_start);
        end_sum     = {1'b0, r_start} + {1'b0, r_len};
        match_end   = r_valid && (end_sum == {1'b0, i_req_start});
        match_start = r_valid && ({1'b0, r_start} == i_req_end);
        fit         = r_valid && (r_len >= i_req_size);
        rest        = r_len - i_req_size;
        empties     = (r_len == i_req_size);
        if (i_ctl.kind == KIND_RELEASE) begin
            // insert point: first cell that is empty or whose start is above the released start
            gen       = i_l_le && !le;
            gen_tok   = '{hit: 1'b1, rm: i_l_match_end, jn: match_start};
            gen_grant = '0;
        end else begin
            gen       = fit && !r_tok.hit;
            gen_tok   = '{hit: 1'b1, rm: empties, jn: 1'b0};
            gen_grant = r_start + rest;
        end
        own_tok = gen ? gen_tok : r_tok;
        sum1    = {2'b00, r_len} + {2'b00, i_req_size};
        sum2    = sum1 + {2'b00, i_r_len};
        sat1    = (sum1 > {2'b00, LEN_MAX}) ? LEN_MAX : sum1[AW-1:0];
        sat2    = (sum2 > {2'b00, LEN_MAX}) ? LEN_MAX : sum2[AW-1:0];
    end

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_len   = r_len;
        n_tok   = r_tok;
        n_grant = r_grant;
        if (i_ctl.reload) begin
            n_valid = i_head && i_ld_valid;
            n_start = i_head ? i_ld_start : '0;
            n_len   = i_head ? i_ld_len : '0;
            n_tok   = '0;
            n_grant = '0;
        end else if (i_ctl.scan) begin
            n_tok   = i_l_tok;
            n_grant = i_l_grant;
        end else if (i_ctl.apply) begin
            if (i_ctl.kind == KIND_ALLOC) begin
                if ((gen && empties) || (!gen && r_tok.hit && r_tok.rm)) begin
                    // close the gap left by the emptied extent
                    n_valid = i_r_valid;
                    n_start = i_r_start;
                    n_len   = i_r_len;
                end else if (gen) begin
                    n_len = rest;
                end
            end else begin
                if (own_tok.hit) begin
                    if (own_tok.rm && own_tok.jn) begin
                        n_valid = i_r_valid;
                        n_start = i_r_start;
                        n_len   = i_r_len;
                    end else if (own_tok.jn) begin
                        if (gen) begin
                            n_start = i_req_start;
                            n_len   = sat1;
                        end
                    end else if (!own_tok.rm && !i_ctl.full) begin
                        if (gen) begin
                            n_valid = 1'b1;
                            n_start = i_req_start;
                            n_len   = i_req_size;
                        end else begin
                            n_valid = i_l_valid;
                            n_start = i_l_start;
                            n_len   = i_l_len;
                        end
                    end
                end else if (le && !i_r_le && match_end) begin
                    // predecessor of the insert point absorbs the block
                    n_len = i_r_match_start ? sat2 : sat1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid <= n_valid;
        r_start <= n_start;
        r_len   <= n_len;
        r_tok   <= n_tok;
        r_grant <= n_grant;
    end

    assign o_valid       = r_valid;
    assign o_start       = r_start;
    assign o_len         = r_len;
    assign o_le          = le;
    assign o_match_end   = match_end;
    assign o_match_start = match_start;
    assign o_tok         = own_tok;
    assign o_grant       = gen ? gen_grant : r_grant;

endmodule

`default_nettype wire

// ===== rtl/first_fit_extent_allocator_core.sv =====
// top level of the first-fit extent allocator: control and the chain of extent cells
`timescale 1ns / 1ps
`default_nettype none

// first-fit allocator over an address-ordered table of free extents
// - command channel: an item (i_kind, i_block_start, i_block_size) is taken at a rising
//   edge with start high and busy low; kind 0 allocates, kind 1 releases
// - result channel: o_done is high for one cycle with o_granted_start and o_status;
//   the receiver cannot stall, each result is taken in the cycle it is shown
// - configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; writing
//   region_base or region_size reloads the table to one extent covering the region, or none if it is empty;
//   o_cfg_ready is high only while idle
// - the table is a row of MAX_EXTENTS cells, one extent per cell, kept in address order
// - an item of nonzero size passes through the scan state, in which the search token ripples
//   one cell per cycle down the chain, then the apply state, in which every cell shifts,
//   merges or shrinks at once; busy stays high through both, and the result strobe follows
//   the apply edge
// - a zero-size item gives its result in the next cycle and busy stays low
// - synchronous reset reloads the table with base 0 and size 65535 and returns to idle
module first_fit_extent_allocator_core #(
    parameter int MAX_EXTENTS = ffea_pkg::DEF_MAX_EXTENTS,
    parameter int ADDR_WIDTH  = ffea_pkg::DEF_ADDR_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_kind,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_block_start,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_block_size,
    output logic                           o_done,
    output logic [ffea_pkg::FIELD_W-1:0]   o_granted_start,
    output logic [ffea_pkg::STATUS_W-1:0]  o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_cfg_data
);
    import ffea_pkg::*;

    localparam int N     = MAX_EXTENTS;
    localparam int AW    = ADDR_WIDTH;
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    // control state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_scan_cnt, n_scan_cnt;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [FIELD_W-1:0]   r_region_base, r_region_size;
    logic                 r_done, n_done;

    // request and result words
    logic                 r_kind;
    logic [AW-1:0]        r_req_start, r_req_size;
    logic [AW:0]          r_req_end;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [AW-1:0]        r_granted, n_granted;

    logic                 accept, cfg_wr, reload, is_zero, full;
    logic [FIELD_W-1:0]   n_region_base, n_region_size;
    logic [AW-1:0]        ld_base, ld_size, ld_len, in_start, in_size, rel_size;
    logic [AW:0]          ld_room, in_room;
    logic                 ld_valid;
    logic                 rel_jp, rel_jn;
    t_cell_ctl            ctl;

    // chain buses, read by the neighboring cells and, for the last cell, by the control
    logic [N-1:0]         c_valid, c_le, c_me, c_ms;
    logic [AW-1:0]        c_start [N];
    logic [AW-1:0]        c_len   [N];
    logic [AW-1:0]        c_grant [N];
    t_tok                 c_tok   [N];

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign full        = (r_count == CNT_W'(MAX_EXTENTS));

    // region registers as they stand after this edge, and the clipped reload extent
    always_comb begin
        n_region_base = r_region_base;
        n_region_size = r_region_size;
        if (!i_rst_n) begin
            n_region_base = REGION_BASE_RST;
            n_region_size = REGION_SIZE_RST;
        end else if (cfg_wr && (i_cfg_index == REG_REGION_BASE)) begin
            n_region_base = i_cfg_data;
        end else if (cfg_wr && (i_cfg_index == REG_REGION_SIZE)) begin
            n_region_size = i_cfg_data;
        end
        reload   = !i_rst_n || (cfg_wr && ((i_cfg_index == REG_REGION_BASE) ||
                                           (i_cfg_index == REG_REGION_SIZE)));
        ld_base  = AW'(n_region_base);
        ld_size  = AW'(n_region_size);
        // room left above base: 2^AW - base
        ld_room  = {1'b1, {AW{1'b0}}} - {1'b0, ld_base};
        ld_len   = ({1'b0, ld_size} > ld_room) ? ld_room[AW-1:0] : ld_size;
        ld_valid = (ld_len != '0);
    end

    // incoming item, release size clipped to the top of the address space
    always_comb begin
        in_start = AW'(i_block_start);
        in_size  = AW'(i_block_size);
        is_zero  = (in_size == '0);
        in_room  = {1'b1, {AW{1'b0}}} - {1'b0, in_start};
        rel_size = ({1'b0, in_size} > in_room) ? in_room[AW-1:0] : in_size;
    end

    always_comb begin
        ctl.scan   = (r_state == ST_SCAN);
        ctl.apply  = (r_state == ST_APPLY);
        ctl.reload = reload;
        ctl.kind   = r_kind;
        ctl.full   = full;
    end

    // release outcome: no insert point means every extent starts at or below the block
    assign rel_jp = c_tok[N-1].hit ? c_tok[N-1].rm : c_me[N-1];
    assign rel_jn = c_tok[N-1].hit && c_tok[N-1].jn;

    // next state and result
    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        n_count    = r_count;
        n_done     = 1'b0;
        n_status   = r_status;
        n_granted  = r_granted;
        case (r_state)
            ST_IDLE: begin
                n_scan_cnt = '0;
                if (accept) begin
                    if (is_zero) begin
                        n_done    = 1'b1;
                        n_status  = STS_ZERO;
                        n_granted = '0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                if (r_scan_cnt == CNT_W'(MAX_EXTENTS - 1)) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_kind == KIND_ALLOC) begin
                    if (c_tok[N-1].hit) begin
                        n_status  = STS_OK;
                        n_granted = c_grant[N-1];
                        if (c_tok[N-1].rm) begin
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        n_status  = STS_NOFIT;
                        n_granted = '0;
                    end
                end else begin
                    n_granted = '0;
                    n_status  = STS_OK;
                    if (rel_jp && rel_jn) begin
                        n_count = r_count - 1'b1;
                    end else if (!rel_jp && !rel_jn) begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (reload) begin
            n_count = CNT_W'(ld_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_scan_cnt    <= '0;
            r_count       <= CNT_W'(ld_valid);
            r_done        <= 1'b0;
            r_region_base <= REGION_BASE_RST;
            r_region_size <= REGION_SIZE_RST;
        end else begin
            r_state       <= n_state;
            r_scan_cnt    <= n_scan_cnt;
            r_count       <= n_count;
            r_done        <= n_done;
            r_region_base <= n_region_base;
            r_region_size <= n_region_size;
        end
    end

    // request and result words
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_req_start <= in_start;
            r_req_size  <= (i_kind == KIND_RELEASE) ? rel_size : in_size;
            r_req_end   <= {1'b0, in_start} + {1'b0, rel_size};
        end
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_start = FIELD_W'(r_granted);

    // the chain: cell 0 sees a left edge that reads as "at or below", the last cell
    // sees an empty right neighbor
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        logic          l_valid, l_le, l_me;
        logic [AW-1:0] l_start, l_len, l_grant;
        t_tok          l_tok;
        logic          r_valid_nb, r_le_nb, r_ms_nb;
        logic [AW-1:0] r_start_nb, r_len_nb;

        if (gi == 0) begin : g_left_edge
            assign l_valid = 1'b0;
            assign l_le    = 1'b1;
            assign l_me    = 1'b0;
            assign l_start = '0;
            assign l_len   = '0;
            assign l_grant = '0;
            assign l_tok   = '0;
        end else begin : g_left_link
            assign l_valid = c_valid[gi-1];
            assign l_le    = c_le[gi-1];
            assign l_me    = c_me[gi-1];
            assign l_start = c_start[gi-1];
            assign l_len   = c_len[gi-1];
            assign l_grant = c_grant[gi-1];
            assign l_tok   = c_tok[gi-1];
        end

        if (gi == N - 1) begin : g_right_edge
            assign r_valid_nb = 1'b0;
            assign r_le_nb    = 1'b0;
            assign r_ms_nb    = 1'b0;
            assign r_start_nb = '0;
            assign r_len_nb   = '0;
        end else begin : g_right_link
            assign r_valid_nb = c_valid[gi+1];
            assign r_le_nb    = c_le[gi+1];
            assign r_ms_nb    = c_ms[gi+1];
            assign r_start_nb = c_start[gi+1];
            assign r_len_nb   = c_len[gi+1];
        end

        ffea_cell #(
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctl           (ctl),
            .i_head          ((gi == 0) ? 1'b1 : 1'b0),
            .i_req_start     (r_req_start),
            .i_req_size      (r_req_size),
            .i_req_end       (r_req_end),
            .i_ld_start      (ld_base),
            .i_ld_len        (ld_len),
            .i_ld_valid      (ld_valid),
            .i_l_valid       (l_valid),
            .i_l_start       (l_start),
            .i_l_len         (l_len),
            .i_l_le          (l_le),
            .i_l_match_end   (l_me),
            .i_l_tok         (l_tok),
            .i_l_grant       (l_grant),
            .i_r_valid       (r_valid_nb),
            .i_r_start       (r_start_nb),
            .i_r_len         (r_len_nb),
            .i_r_le          (r_le_nb),
            .i_r_match_start (r_ms_nb),
            .o_valid         (c_valid[gi]),
            .o_start         (c_start[gi]),
            .o_len           (c_len[gi]),
            .o_le            (c_le[gi]),
            .o_match_end     (c_me[gi]),
            .o_match_start   (c_ms[gi]),
            .o_tok           (c_tok[gi]),
            .o_grant         (c_grant[gi])
        );
    end

endmodule

`default_nettype wire

// ===== tb/ffea_checker.sv =====
// checker for the first-fit extent allocator: free-list predictor and result comparison
`timescale 1ns / 1ps

module ffea_checker
    import ffea_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_kind,
    input  logic [FIELD_W-1:0]    i_block_start,
    input  logic [FIELD_W-1:0]    i_block_size,
    input  logic                  o_done,
    input  logic [FIELD_W-1:0]    o_granted_start,
    input  logic [STATUS_W-1:0]   o_status,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FIELD_W-1:0]    i_cfg_data,
    input  logic                  i_end_check,
    output int                    o_err_count
);

    localparam int NUM_EXT = DEF_MAX_EXTENTS;
    localparam int SPACE   = 1 << DEF_ADDR_WIDTH;
    localparam int LEN_MAX = SPACE - 1;

    typedef struct packed {
        logic [FIELD_W-1:0]  granted;
        logic [STATUS_W-1:0] status;
    } t_grant;

    t_grant expected_grants[$];

    logic [FIELD_W-1:0] region_base;
    logic [FIELD_W-1:0] region_size;
    logic [FIELD_W-1:0] free_start[NUM_EXT];
    logic [FIELD_W-1:0] free_len[NUM_EXT];
    int                 free_count;

    int n_alloc, n_release, n_cfg;
    int n_ok, n_nofit, n_full, n_zero;

    task automatic report_mismatch(input string what);
        if (o_err_count < 30) $display("[%0t] mismatch: %s", $time, what);
        o_err_count++;
    endtask

    function automatic void reload_free_list();
        int sz;
        sz = int'(region_size);
        if (sz > SPACE - int'(region_base)) sz = SPACE - int'(region_base);
        for (int k = 0; k < NUM_EXT; k++) begin
            free_start[k] = '0;
            free_len[k]   = '0;
        end
        free_start[0] = region_base;
        free_len[0]   = sz;
        free_count    = (sz != 0) ? 1 : 0;
    endfunction

    function automatic void drop_extent(input int idx);
        for (int k = idx; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k+1];
            free_len[k]   = free_len[k+1];
        end
        free_count--;
        free_start[free_count] = '0;
        free_len[free_count]   = '0;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_len(input int v);
        if (v > LEN_MAX) v = LEN_MAX;
        return v;
    endfunction

    // first fit, carved from the top end of the extent
    function automatic logic [STATUS_W-1:0] carve_block(input logic [FIELD_W-1:0] bsize,
                                                        output logic [FIELD_W-1:0] granted);
        granted = '0;
        for (int i = 0; i < free_count; i++) begin
            if (free_len[i] >= bsize) begin
                free_len[i] = free_len[i] - bsize;
                granted     = free_start[i] + free_len[i];
                if (free_len[i] == '0) drop_extent(i);
                return STS_OK;
            end
        end
        return STS_NOFIT;
    endfunction

    // insert in address order, merging on exact adjacency only
    function automatic logic [STATUS_W-1:0] merge_release(input logic [FIELD_W-1:0] bstart,
                                                          input logic [FIELD_W-1:0] bsize);
        int   s, n, e, pos;
        logic join_prev, join_next;
        s = int'(bstart);
        n = int'(bsize);
        if (n > SPACE - s) n = SPACE - s;
        e   = s + n;
        pos = 0;
        while (pos < free_count && int'(free_start[pos]) <= s) pos++;
        join_prev = 1'b0;
        join_next = 1'b0;
        if (pos > 0) join_prev = (int'(free_start[pos-1]) + int'(free_len[pos-1]) == s);
        if (pos < free_count) join_next = (int'(free_start[pos]) == e);
        if (join_prev && join_next) begin
            free_len[pos-1] = sat_len(int'(free_len[pos-1]) + n + int'(free_len[pos]));
            drop_extent(pos);
        end else if (join_prev) begin
            free_len[pos-1] = sat_len(int'(free_len[pos-1]) + n);
        end else if (join_next) begin
            free_start[pos] = bstart;
            free_len[pos]   = sat_len(int'(free_len[pos]) + n);
        end else begin
            if (free_count >= NUM_EXT) return STS_FULL;
            for (int k = free_count; k > pos; k--) begin
                free_start[k] = free_start[k-1];
                free_len[k]   = free_len[k-1];
            end
            free_start[pos] = bstart;
            free_len[pos]   = n;
            free_count++;
        end
        return STS_OK;
    endfunction

    initial begin
        o_err_count = 0;
        region_base = REGION_BASE_RST;
        region_size = REGION_SIZE_RST;
        reload_free_list();
    end

    always @(posedge i_clk) begin : watch
        t_grant              want;
        logic [STATUS_W-1:0] st;
        logic [FIELD_W-1:0]  g;
        if (!i_rst_n) begin
            region_base = REGION_BASE_RST;
            region_size = REGION_SIZE_RST;
            reload_free_list();
            expected_grants.delete();
        end else begin
            if (o_done) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word: start %h status %0d",
                                              o_granted_start, o_status));
                end else begin
                    want = expected_grants.pop_front();
                    if (o_granted_start !== want.granted)
                        report_mismatch($sformatf("granted_start %h, expected %h",
                                                  o_granted_start, want.granted));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                if (i_cfg_index == REG_REGION_BASE) begin
                    region_base = i_cfg_data;
                    reload_free_list();
                end else if (i_cfg_index == REG_REGION_SIZE) begin
                    region_size = i_cfg_data;
                    reload_free_list();
                end
            end
            if (start && !busy) begin
                g = '0;
                if (i_block_size == '0) begin
                    st = STS_ZERO;
                end else if (i_kind == KIND_ALLOC) begin
                    st = carve_block(i_block_size, g);
                end else begin
                    st = merge_release(i_block_start, i_block_size);
                end
                if (st != STS_OK) g = '0;
                if (i_kind == KIND_ALLOC) n_alloc++;
                else n_release++;
                case (st)
                    STS_OK:    n_ok++;
                    STS_NOFIT: n_nofit++;
                    STS_FULL:  n_full++;
                    default:   n_zero++;
                endcase
                want.granted = g;
                want.status  = st;
                expected_grants.push_back(want);
            end
        end
    end

    always @(posedge i_end_check) begin
        if (expected_grants.size() != 0)
            report_mismatch($sformatf("%0d expected result words never arrived",
                                      expected_grants.size()));
        $display("covered %0d allocations, %0d releases, %0d register writes",
                 n_alloc, n_release, n_cfg);
        $display("outcomes: %0d granted, %0d no fit, %0d table full, %0d zero size",
                 n_ok, n_nofit, n_full, n_zero);
    end

endmodule

// ===== tb/tb_first_fit_extent_allocator_core.sv =====
// testbench top for the first-fit extent allocator: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_first_fit_extent_allocator_core;
    import ffea_pkg::*;

    // cycles with no word moving on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // settle wait before the end check, sized from the table depth
    localparam int SETTLE      = DEF_MAX_EXTENTS + 6;
    localparam int SPACE       = 1 << DEF_ADDR_WIDTH;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_kind;
    logic [FIELD_W-1:0]   i_block_start;
    logic [FIELD_W-1:0]   i_block_size;
    logic                 o_done;
    logic [FIELD_W-1:0]   o_granted_start;
    logic [STATUS_W-1:0]  o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;
    logic                 end_check;
    int                   err_count;

    // request words sent but not yet answered, kept only to steer the stimulus
    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] size;
    } t_request;

    // blocks currently handed out by the allocator, source of well-formed releases
    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] len;
    } t_block;

    t_request outstanding_reqs[$];
    t_block   held_blocks[$];

    logic [FIELD_W-1:0] cur_base;
    int                 cur_span;
    int                 quiet_cycles;

    first_fit_extent_allocator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_block_start   (i_block_start),
        .i_block_size    (i_block_size),
        .o_done          (o_done),
        .o_granted_start (o_granted_start),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ffea_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_block_start   (i_block_start),
        .i_block_size    (i_block_size),
        .o_done          (o_done),
        .o_granted_start (o_granted_start),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_end_check     (end_check),
        .o_err_count     (err_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // pair each result word with its request; granted blocks become release candidates
    always @(posedge i_clk) begin : track
        t_request req;
        t_block   blk;
        if (i_rst_n && o_done && outstanding_reqs.size() != 0) begin
            req = outstanding_reqs.pop_front();
            if (req.kind == KIND_ALLOC && o_status == STS_OK) begin
                blk.base = o_granted_start;
                blk.len  = req.size;
                held_blocks.push_back(blk);
            end
        end
    end

    // watchdog: any accepted word on any channel resets the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one request word; start stays high after accept until the next negedge decides
    task automatic send_word(input logic kind, input logic [FIELD_W-1:0] bstart,
                             input logic [FIELD_W-1:0] bsize);
        t_request req;
        @(negedge i_clk);
        start         <= 1'b1;
        i_kind        <= kind;
        i_block_start <= bstart;
        i_block_size  <= bsize;
        do @(posedge i_clk); while (busy);
        req.kind = kind;
        req.size = bsize;
        outstanding_reqs.push_back(req);
    endtask

    // random sender gap, long enough at times to cover a whole busy stretch
    task automatic pace(input int idle_pct);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
    endtask

    // hold off the sender until every answer is back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding_reqs.size() != 0) @(posedge i_clk);
    endtask

    // both region registers, back to back; each write reloads the table
    task automatic set_region(input logic [FIELD_W-1:0] base, input logic [FIELD_W-1:0] size);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_REGION_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= REG_REGION_SIZE;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_base = base;
        cur_span = int'(size);
        if (cur_span > SPACE - int'(base)) cur_span = SPACE - int'(base);
        held_blocks.delete();
    endtask

    // carve a region into 34 equal blocks, free every other one until the table
    // overflows, then free the rest so the holes merge with their freed neighbors
    task automatic fragment_round(input int unit, input int idle_pct);
        logic [FIELD_W-1:0] base;
        base = $urandom_range(0, SPACE - 34 * unit);
        set_region(base, 34 * unit);
        repeat (34) begin
            send_word(KIND_ALLOC, $urandom, unit);
            pace(idle_pct);
        end
        for (int k = 0; k <= 16; k++) begin
            send_word(KIND_RELEASE, base + 2 * k * unit, unit);
            pace(idle_pct);
        end
        for (int k = 0; k <= 16; k++) begin
            send_word(KIND_RELEASE, base + (2 * k + 1) * unit, unit);
            pace(idle_pct);
        end
        // the block dropped on overflow goes back last
        send_word(KIND_RELEASE, base + 32 * unit, unit);
    endtask

    // mix of allocations, releases of held blocks (whole or split) and stray releases
    task automatic random_words(input int count, input int idle_pct);
        int                 r, idx, lim, cut;
        t_block             blk;
        logic [FIELD_W-1:0] bstart, bsize;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 85 && held_blocks.size() == 0)) begin
                r   = $urandom_range(0, 99);
                lim = cur_span / 12 + 1;
                if (lim > 65535) lim = 65535;
                if (r < 5) bsize = '0;
                else if (r < 15) bsize = $urandom;
                else if (r < 20) bsize = (cur_span == 0) ? 1 : cur_span;
                else bsize = $urandom_range(1, lim);
                send_word(KIND_ALLOC, $urandom, bsize);
            end else if (r < 85) begin
                idx = $urandom_range(0, held_blocks.size() - 1);
                blk = held_blocks[idx];
                held_blocks.delete(idx);
                if (blk.len > 1 && $urandom_range(0, 3) == 0) begin
                    // free the low part now, keep the rest for later
                    cut = $urandom_range(1, int'(blk.len) - 1);
                    send_word(KIND_RELEASE, blk.base, cut);
                    blk.base = blk.base + cut;
                    blk.len  = blk.len - cut;
                    held_blocks.push_back(blk);
                end else begin
                    send_word(KIND_RELEASE, blk.base, blk.len);
                end
            end else begin
                // stray release: often near the region so overlaps and adjacency occur
                if ($urandom_range(0, 1) == 0) bstart = $urandom;
                else bstart = cur_base + $urandom_range(0, cur_span);
                r = $urandom_range(0, 99);
                if (r < 5) bsize = '0;
                else if (r < 50) bsize = $urandom_range(1, 64);
                else bsize = $urandom;
                send_word(KIND_RELEASE, bstart, bsize);
            end
            pace(idle_pct);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = KIND_ALLOC;
        i_block_start = '0;
        i_block_size  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_REGION_BASE;
        i_cfg_data    = '0;
        end_check     = 1'b0;
        quiet_cycles  = 0;
        cur_base      = REGION_BASE_RST;
        cur_span      = int'(REGION_SIZE_RST);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default region 0 / 65535
        send_word(KIND_ALLOC, 16'hFFFF, 16'h0000);   // zero size allocate
        send_word(KIND_RELEASE, 16'hFFFF, 16'h0000); // zero size release
        send_word(KIND_ALLOC, 16'h0000, 16'h0001);   // one unit off the top
        send_word(KIND_ALLOC, 16'h0000, 16'hFFFF);   // no fit
        send_word(KIND_RELEASE, 16'hFFFE, 16'h0001); // joins predecessor
        send_word(KIND_ALLOC, 16'h0000, 16'hFFFF);   // whole region, table empties
        send_word(KIND_ALLOC, 16'h0000, 16'h0001);   // empty table, no fit
        send_word(KIND_RELEASE, 16'h8000, 16'hFFFF); // clipped at the address space end
        send_word(KIND_RELEASE, 16'h0000, 16'h8000); // joins successor, length saturates
        send_word(KIND_RELEASE, 16'hFFFF, 16'hFFFF); // clipped to one, joins, saturated
        send_word(KIND_ALLOC, 16'h0000, 16'hFFFF);
        send_word(KIND_RELEASE, 16'h5555, 16'h00AA);
        send_word(KIND_RELEASE, 16'hAAAA, 16'h5555); // inserted after
        send_word(KIND_RELEASE, 16'h1000, 16'h0010); // inserted before
        send_word(KIND_RELEASE, 16'h1010, 16'h4545); // joins both sides
        send_word(KIND_ALLOC, 16'h0000, 16'h5000);   // skips the first extent
        send_word(KIND_ALLOC, 16'h0000, 16'h45FF);   // exact fit removes first extent
        send_word(KIND_ALLOC, 16'h0000, 16'h0555);   // exact fit, table empty
        set_region(16'hFFFF, 16'hFFFF);              // size clipped to one
        send_word(KIND_ALLOC, 16'h0000, 16'h0002);
        send_word(KIND_ALLOC, 16'h0000, 16'h0001);
        set_region(16'h0000, 16'h0000);              // empty region
        send_word(KIND_ALLOC, 16'h0000, 16'h0001);
        send_word(KIND_RELEASE, 16'h0000, 16'h0001);

        // overflow and merge patterns, then random traffic across several regions
        fragment_round(1, 0);
        set_region(REGION_BASE_RST, REGION_SIZE_RST);
        random_words(130, 0);
        set_region($urandom, $urandom_range(64, 2048));
        random_words(130, 64);
        fragment_round($urandom_range(1, 8), 38);
        set_region($urandom, $urandom);
        random_words(130, 38);
        set_region($urandom, 16'h0000);
        random_words(40, 38);
        set_region($urandom_range(0, 65279), 16'h0100);
        random_words(150, 64);
        set_region($urandom_range(0, 61439), 16'h1000);
        random_words(150, 0);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
